FILE: rtl/core/srb_pkg.sv
package srb_pkg;

    // Fixed field widths and input channel count
    localparam int KEY_W    = 32;
    localparam int SAMPLE_W = 16;
    localparam int IN_CH    = 4;

    // Register indexes (paddr[2])
    localparam logic REG_GAIN      = 1'b0;
    localparam logic REG_MAX_DELAY = 1'b1;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [KEY_W-1:0]           key_t;

    // Packet sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_CHECK,
        ST_INS_FIRST,
        ST_INS_SECOND,
        ST_EMIT
    } srb_state_t;

    // Command broadcast to every cell of the sorted chain
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_SHIFT
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        key_t     key;
    } cell_ctrl_t;

endpackage

FILE: rtl/core/srb_cell.sv
module srb_cell
    import srb_pkg::*;
#(
    parameter int NUM_CH = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  cell_ctrl_t ctrl,
    input  sample_t    ins_sample   [NUM_CH],
    input  logic       left_gt,
    input  logic       left_valid,
    input  key_t       left_key,
    input  sample_t    left_sample  [NUM_CH],
    input  logic       right_valid,
    input  key_t       right_key,
    input  sample_t    right_sample [NUM_CH],
    output logic       valid,
    output key_t       key,
    output sample_t    sample       [NUM_CH],
    output logic       gt
);

    logic    valid_reg;
    key_t    key_reg;
    sample_t sample_reg [NUM_CH];

    // an empty cell sorts above any key
    assign gt    = !valid_reg || (key_reg > ctrl.key);
    assign valid = valid_reg;
    assign key   = key_reg;

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            sample[c] = sample_reg[c];
        end
    end

    // occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            unique case (ctrl.op)
                CELL_HOLD: ;
                CELL_INSERT: begin
                    if (gt) begin
                        valid_reg <= left_gt ? left_valid : 1'b1;
                    end
                end
                CELL_SHIFT: valid_reg <= right_valid;
                default: ;
            endcase
        end
    end

    // key and samples: larger entries move right on insert, all move left on emit
    always_ff @(posedge aclk) begin
        unique case (ctrl.op)
            CELL_HOLD: ;
            CELL_INSERT: begin
                if (gt) begin
                    if (left_gt) begin
                        key_reg <= left_key;
                        for (int c = 0; c < NUM_CH; c++) sample_reg[c] <= left_sample[c];
                    end else begin
                        key_reg <= ctrl.key;
                        for (int c = 0; c < NUM_CH; c++) sample_reg[c] <= ins_sample[c];
                    end
                end
            end
            CELL_SHIFT: begin
                key_reg <= right_key;
                for (int c = 0; c < NUM_CH; c++) sample_reg[c] <= right_sample[c];
            end
            default: ;
        endcase
    end

endmodule

FILE: rtl/core/sequence_reorder_buffer_core.sv
// Channel   Ports                                   Moves
// input     s_valid/s_ready, s_packet_number, ...   one packet word, two sample sets
// result    m_valid/m_ready, m_out_sequence, ...    one scaled sample set per word
// config    psel/penable/pwrite/paddr/pwdata/prdata gain, max_delay
//
// A packet passes through accept, sequence reduction, late/wrap check, two
// inserts into the cell chain, then one emit step per result word (a late
// packet returns to idle after the check).
// Insert shifts larger entries right by one cell; emit shifts all cells left.
// Reset (synchronous, active low) empties the chain and clears the wrap offset.
// A stalled result word holds the emit step until the output register frees.
module sequence_reorder_buffer_core
    import srb_pkg::*;
#(
    parameter int MAP_SIZE = 16,
    parameter int SEQ_WRAP = 65536,
    parameter int CHANNELS = 4
) (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic        [15:0] s_packet_number,
    input  logic signed [15:0] s_first_ch0,
    input  logic signed [15:0] s_first_ch1,
    input  logic signed [15:0] s_first_ch2,
    input  logic signed [15:0] s_first_ch3,
    input  logic signed [15:0] s_second_ch0,
    input  logic signed [15:0] s_second_ch1,
    input  logic signed [15:0] s_second_ch2,
    input  logic signed [15:0] s_second_ch3,

    output logic               m_valid,
    input  logic               m_ready,
    output logic        [31:0] m_out_sequence,
    output logic signed [31:0] m_out_ch0,
    output logic signed [31:0] m_out_ch1,
    output logic signed [31:0] m_out_ch2,
    output logic signed [31:0] m_out_ch3,
    output logic               m_out_last,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic         [2:0] paddr,
    input  logic        [31:0] pwdata,
    output logic        [31:0] prdata,
    output logic               pready
);

    localparam int SLOTS    = MAP_SIZE + 2;
    localparam int STORE_CH = (CHANNELS < IN_CH) ? CHANNELS : IN_CH;

    // reciprocal for the sequence reduction; estimate is low by at most one
    localparam longint unsigned RECIP_L = (64'd1 << 32) / SEQ_WRAP;
    localparam logic [32:0]     RECIP   = 33'(RECIP_L);
    localparam logic [33:0]     WRAP34  = 34'(SEQ_WRAP);
    localparam key_t            WRAP32  = 32'(SEQ_WRAP);

    // configuration
    logic signed [15:0] gain_reg;
    logic        [15:0] max_delay_reg;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg      <= 16'sd256;
            max_delay_reg <= 16'd1024;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                REG_GAIN:      gain_reg      <= pwdata[15:0];
                REG_MAX_DELAY: max_delay_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_GAIN:      prdata = {16'd0, gain_reg};
            REG_MAX_DELAY: prdata = {16'd0, max_delay_reg};
            default:       prdata = '0;
        endcase
    end

    // cell chain
    cell_ctrl_t         ctrl;
    sample_t            ins_sample   [STORE_CH];
    logic [SLOTS-1:0]   cell_valid;
    key_t               cell_key     [SLOTS];
    sample_t            cell_sample  [SLOTS][STORE_CH];
    logic [SLOTS-1:0]   cell_gt;
    logic [SLOTS-1:0]   left_gt;
    logic [SLOTS-1:0]   left_valid;
    key_t               left_key     [SLOTS];
    sample_t            left_sample  [SLOTS][STORE_CH];
    logic [SLOTS-1:0]   right_valid;
    key_t               right_key    [SLOTS];
    sample_t            right_sample [SLOTS][STORE_CH];

    for (genvar i = 0; i < SLOTS; i++) begin : g_cell
        if (i == 0) begin : g_head
            assign left_gt[i]    = 1'b0;
            assign left_valid[i] = 1'b0;
            assign left_key[i]   = '0;
            for (genvar c = 0; c < STORE_CH; c++) begin : g_ch
                assign left_sample[i][c] = '0;
            end
        end else begin : g_link_left
            assign left_gt[i]    = cell_gt[i-1];
            assign left_valid[i] = cell_valid[i-1];
            assign left_key[i]   = cell_key[i-1];
            for (genvar c = 0; c < STORE_CH; c++) begin : g_ch
                assign left_sample[i][c] = cell_sample[i-1][c];
            end
        end

        if (i == SLOTS - 1) begin : g_tail
            assign right_valid[i] = 1'b0;
            assign right_key[i]   = '0;
            for (genvar c = 0; c < STORE_CH; c++) begin : g_ch
                assign right_sample[i][c] = '0;
            end
        end else begin : g_link_right
            assign right_valid[i] = cell_valid[i+1];
            assign right_key[i]   = cell_key[i+1];
            for (genvar c = 0; c < STORE_CH; c++) begin : g_ch
                assign right_sample[i][c] = cell_sample[i+1][c];
            end
        end

        srb_cell #(
            .NUM_CH (STORE_CH)
        ) u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .ctrl         (ctrl),
            .ins_sample   (ins_sample),
            .left_gt      (left_gt[i]),
            .left_valid   (left_valid[i]),
            .left_key     (left_key[i]),
            .left_sample  (left_sample[i]),
            .right_valid  (right_valid[i]),
            .right_key    (right_key[i]),
            .right_sample (right_sample[i]),
            .valid        (cell_valid[i]),
            .key          (cell_key[i]),
            .sample       (cell_sample[i]),
            .gt           (cell_gt[i])
        );
    end

    // packet registers
    srb_state_t  state_reg, state_next;
    logic [15:0] pn_reg;
    logic [16:0] q_reg;
    logic [15:0] raw_n_reg;
    key_t        key_reg;
    key_t        wrap_offset_reg;
    sample_t     first_reg  [STORE_CH];
    sample_t     second_reg [STORE_CH];
    sample_t     in_first   [IN_CH];
    sample_t     in_second  [IN_CH];

    assign in_first  = '{s_first_ch0, s_first_ch1, s_first_ch2, s_first_ch3};
    assign in_second = '{s_second_ch0, s_second_ch1, s_second_ch2, s_second_ch3};

    logic        accept;
    logic [48:0] q_prod;
    logic [33:0] q_times_wrap;
    logic [33:0] rem_raw;
    logic [33:0] rem_fix;
    key_t        n_ext;
    key_t        gap;
    logic        below;
    logic        late;
    logic        do_wrap;
    logic        emit;
    logic        dup_key;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // sequence number modulo SEQ_WRAP, then extension and late/wrap test
    assign q_prod       = 49'(s_packet_number) * 49'(RECIP);
    assign q_times_wrap = 34'(q_reg) * WRAP34;
    assign rem_raw      = 34'(pn_reg) - q_times_wrap;
    assign rem_fix      = (rem_raw >= WRAP34) ? (rem_raw - WRAP34) : rem_raw;

    assign n_ext   = 32'(raw_n_reg) + wrap_offset_reg;
    assign gap     = cell_key[0] - n_ext;
    assign below   = cell_valid[0] && (n_ext < cell_key[0]);
    assign late    = below && (gap <= {16'd0, max_delay_reg});
    assign do_wrap = below && !late;

    always_comb begin
        for (int c = 0; c < STORE_CH; c++) begin
            ins_sample[c] = (state_reg == ST_INS_SECOND) ? second_reg[c] : first_reg[c];
        end
    end

    // key being inserted already held somewhere in the chain
    always_comb begin
        dup_key = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            if (cell_valid[i] && (cell_key[i] == key_reg)) dup_key = 1'b1;
        end
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        ctrl.op    = CELL_HOLD;
        ctrl.key   = key_reg;
        emit       = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) state_next = ST_MOD;
            end
            ST_MOD: state_next = ST_CHECK;
            ST_CHECK: state_next = late ? ST_IDLE : ST_INS_FIRST;
            ST_INS_FIRST: begin
                if (!dup_key) ctrl.op = CELL_INSERT;
                state_next = ST_INS_SECOND;
            end
            ST_INS_SECOND: begin
                if (!dup_key) ctrl.op = CELL_INSERT;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (cell_valid[MAP_SIZE]) begin
                    if (!m_valid || m_ready) begin
                        emit    = 1'b1;
                        ctrl.op = CELL_SHIFT;
                        if (!cell_valid[MAP_SIZE+1]) state_next = ST_IDLE;
                    end
                end else begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // wrap offset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wrap_offset_reg <= '0;
        end else if (state_reg == ST_CHECK && do_wrap) begin
            wrap_offset_reg <= wrap_offset_reg + WRAP32;
        end
    end

    // packet payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            pn_reg <= s_packet_number;
            q_reg  <= q_prod[48:32];
            for (int c = 0; c < STORE_CH; c++) begin
                first_reg[c]  <= in_first[c];
                second_reg[c] <= in_second[c];
            end
        end
        if (state_reg == ST_MOD) raw_n_reg <= rem_fix[15:0];
        if (state_reg == ST_CHECK) key_reg <= do_wrap ? (n_ext + WRAP32) : n_ext;
        if (state_reg == ST_INS_FIRST) key_reg <= key_reg + 32'd1;
    end

    // result word register
    logic               m_valid_reg;
    key_t               out_seq_reg;
    logic signed [31:0] out_ch_reg [IN_CH];
    logic               out_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_seq_reg  <= cell_key[0];
            out_last_reg <= !cell_valid[MAP_SIZE+1];
        end
    end

    for (genvar c = 0; c < IN_CH; c++) begin : g_out_ch
        if (c < STORE_CH) begin : g_scaled
            always_ff @(posedge aclk) begin
                if (emit) out_ch_reg[c] <= 32'(cell_sample[0][c]) * 32'(gain_reg);
            end
        end else begin : g_unused
            always_ff @(posedge aclk) begin
                if (emit) out_ch_reg[c] <= '0;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_out_sequence = out_seq_reg;
    assign m_out_ch0      = out_ch_reg[0];
    assign m_out_ch1      = out_ch_reg[1];
    assign m_out_ch2      = out_ch_reg[2];
    assign m_out_ch3      = out_ch_reg[3];
    assign m_out_last     = out_last_reg;

    // chain stays packed at the head and strictly ascending
    logic chain_ok;

    always_comb begin
        chain_ok = 1'b1;
        for (int i = 0; i < SLOTS - 1; i++) begin
            if (cell_valid[i+1] && (!cell_valid[i] || cell_key[i] >= cell_key[i+1])) begin
                chain_ok = 1'b0;
            end
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn) chain_ok)
        else $error("cell chain out of order or not packed");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !cell_valid[MAP_SIZE])
        else $error("store over capacity between packets");

    assert property (@(posedge aclk) disable iff (!aresetn)
        emit && !cell_valid[MAP_SIZE+1] |=> (state_reg == ST_IDLE))
        else $error("sequencer not idle after last word");

endmodule

FILE: test/srb_result_checker.sv
`timescale 1ns / 100ps

// Watches the packet, result and register ports, keeps its own copy of the
// reorder store and compares every result word with the oldest prediction.
module srb_result_checker
    import srb_pkg::*;
#(
    parameter int MAP_SIZE = 16,
    parameter int SEQ_WRAP = 65536
) (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    input  logic               s_ready,
    input  logic        [15:0] s_packet_number,
    input  logic signed [15:0] s_first_ch0,
    input  logic signed [15:0] s_first_ch1,
    input  logic signed [15:0] s_first_ch2,
    input  logic signed [15:0] s_first_ch3,
    input  logic signed [15:0] s_second_ch0,
    input  logic signed [15:0] s_second_ch1,
    input  logic signed [15:0] s_second_ch2,
    input  logic signed [15:0] s_second_ch3,

    input  logic               m_valid,
    input  logic               m_ready,
    input  logic        [31:0] m_out_sequence,
    input  logic signed [31:0] m_out_ch0,
    input  logic signed [31:0] m_out_ch1,
    input  logic signed [31:0] m_out_ch2,
    input  logic signed [31:0] m_out_ch3,
    input  logic               m_out_last,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic         [2:0] paddr,
    input  logic        [31:0] pwdata,
    input  logic               pready,

    output int                 mismatches,
    output int                 due_count
);

    // two keys land before the overflow is drained
    localparam int SLOTS = MAP_SIZE + 2;

    typedef logic [IN_CH-1:0][SAMPLE_W-1:0] sample_set_t;

    typedef struct packed {
        key_t                  seq;
        logic [IN_CH-1:0][31:0] ch;
        logic                  last;
    } scaled_set_t;

    logic signed [15:0] gain_q88;
    logic        [15:0] late_window;
    key_t               wrap_base;
    key_t               held_key [SLOTS];
    logic               held_used [SLOTS];
    sample_set_t        held_raw [SLOTS];
    scaled_set_t        due_sets [$];

    initial mismatches = 0;
    initial due_count  = 0;

    // slot with the smallest key, -1 when the store is empty
    function automatic int lowest_held();
        int best;
        best = -1;
        for (int i = 0; i < SLOTS; i++) begin
            if (held_used[i] && (best < 0 || held_key[i] < held_key[best]))
                best = i;
        end
        return best;
    endfunction

    function automatic int held_total();
        int n;
        n = 0;
        for (int i = 0; i < SLOTS; i++) begin
            if (held_used[i])
                n++;
        end
        return n;
    endfunction

    // an existing key keeps its samples
    task automatic file_set(input key_t key, input sample_set_t raw);
        int free_slot;
        free_slot = -1;
        for (int i = 0; i < SLOTS; i++) begin
            if (held_used[i] && held_key[i] == key)
                return;
            if (!held_used[i] && free_slot < 0)
                free_slot = i;
        end
        if (free_slot >= 0) begin
            held_key[free_slot]  = key;
            held_raw[free_slot]  = raw;
            held_used[free_slot] = 1'b1;
        end
    endtask

    // extend the number, drop or re-round it, store both sets, drain overflow
    task automatic reorder_packet(input logic [15:0] number, input sample_set_t first,
                                  input sample_set_t second);
        key_t               n;
        key_t               floor_key;
        int                 low;
        int                 emitted;
        scaled_set_t        word;
        logic signed [31:0] wide_raw;
        logic signed [31:0] wide_gain;
        n = (32'(number) % SEQ_WRAP) + wrap_base;
        low = lowest_held();
        if (low >= 0) begin
            floor_key = held_key[low];
            if (n < floor_key) begin
                if (floor_key - n > key_t'(late_window)) begin
                    wrap_base += SEQ_WRAP;
                    n += SEQ_WRAP;
                end else begin
                    return;
                end
            end
        end
        file_set(n, first);
        file_set(n + 1, second);

        emitted = 0;
        wide_gain = gain_q88;
        while (held_total() > MAP_SIZE && emitted < 2) begin
            low = lowest_held();
            word.seq = held_key[low];
            for (int c = 0; c < IN_CH; c++) begin
                wide_raw = $signed(held_raw[low][c]);
                word.ch[c] = wide_raw * wide_gain;
            end
            held_used[low] = 1'b0;
            emitted++;
            word.last = (emitted == 2) || (held_total() <= MAP_SIZE);
            due_sets.push_back(word);
        end
    endtask

    task automatic check_field(input string label, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 'h%0h, got 'h%0h", label, want, got);
            mismatches++;
        end
    endtask

    // everything is sampled at the rising edge, before the block updates
    always @(posedge aclk) begin : watch
        scaled_set_t want;
        if (!aresetn) begin
            gain_q88    = 16'sd256;
            late_window = 16'd1024;
            wrap_base   = '0;
            for (int i = 0; i < SLOTS; i++)
                held_used[i] = 1'b0;
            due_sets.delete();
        end else begin
            // result word against the oldest prediction
            if (m_valid && m_ready) begin
                if (due_sets.size() == 0) begin
                    $error("result word 'h%0h with no prediction waiting", m_out_sequence);
                    mismatches++;
                end else begin
                    want = due_sets.pop_front();
                    check_field("out_sequence", want.seq, m_out_sequence);
                    check_field("out_ch0", want.ch[0], m_out_ch0);
                    check_field("out_ch1", want.ch[1], m_out_ch1);
                    check_field("out_ch2", want.ch[2], m_out_ch2);
                    check_field("out_ch3", want.ch[3], m_out_ch3);
                    check_field("out_last", 32'(want.last), 32'(m_out_last));
                end
            end

            // register writes
            if (psel && penable && pwrite && pready) begin
                case (paddr[2])
                    REG_GAIN:      gain_q88 = pwdata[15:0];
                    REG_MAX_DELAY: late_window = pwdata[15:0];
                    default: ;
                endcase
            end

            // accepted packet word
            if (s_valid && s_ready)
                reorder_packet(s_packet_number,
                               {s_first_ch3, s_first_ch2, s_first_ch1, s_first_ch0},
                               {s_second_ch3, s_second_ch2, s_second_ch1, s_second_ch0});
        end
        due_count = due_sets.size();
    end

endmodule

FILE: test/sequence_reorder_buffer_core_tb.sv
`timescale 1ns / 100ps

module sequence_reorder_buffer_core_tb;
    import srb_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_WAIT  = 12;

    localparam logic [2:0] GAIN_ADDR      = {REG_GAIN, 2'b00};
    localparam logic [2:0] MAX_DELAY_ADDR = {REG_MAX_DELAY, 2'b00};

    typedef logic [IN_CH-1:0][SAMPLE_W-1:0] sample_set_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;

    logic               s_valid = 1'b0;
    logic               s_ready;
    logic        [15:0] s_packet_number = '0;
    logic signed [15:0] s_first_ch0 = '0;
    logic signed [15:0] s_first_ch1 = '0;
    logic signed [15:0] s_first_ch2 = '0;
    logic signed [15:0] s_first_ch3 = '0;
    logic signed [15:0] s_second_ch0 = '0;
    logic signed [15:0] s_second_ch1 = '0;
    logic signed [15:0] s_second_ch2 = '0;
    logic signed [15:0] s_second_ch3 = '0;

    logic               m_valid;
    logic               m_ready = 1'b0;
    logic        [31:0] m_out_sequence;
    logic signed [31:0] m_out_ch0;
    logic signed [31:0] m_out_ch1;
    logic signed [31:0] m_out_ch2;
    logic signed [31:0] m_out_ch3;
    logic               m_out_last;

    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic         [2:0] paddr = '0;
    logic        [31:0] pwdata = '0;
    logic        [31:0] prdata;
    logic               pready;

    int                 mismatches;
    int                 due_count;
    int                 cycle_count = 0;
    int                 send_idle_pct = 0;
    int                 hold_pct = 0;
    logic        [15:0] cursor;

    sequence_reorder_buffer_core dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_packet_number (s_packet_number),
        .s_first_ch0     (s_first_ch0),
        .s_first_ch1     (s_first_ch1),
        .s_first_ch2     (s_first_ch2),
        .s_first_ch3     (s_first_ch3),
        .s_second_ch0    (s_second_ch0),
        .s_second_ch1    (s_second_ch1),
        .s_second_ch2    (s_second_ch2),
        .s_second_ch3    (s_second_ch3),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_sequence  (m_out_sequence),
        .m_out_ch0       (m_out_ch0),
        .m_out_ch1       (m_out_ch1),
        .m_out_ch2       (m_out_ch2),
        .m_out_ch3       (m_out_ch3),
        .m_out_last      (m_out_last),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    srb_result_checker result_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_packet_number (s_packet_number),
        .s_first_ch0     (s_first_ch0),
        .s_first_ch1     (s_first_ch1),
        .s_first_ch2     (s_first_ch2),
        .s_first_ch3     (s_first_ch3),
        .s_second_ch0    (s_second_ch0),
        .s_second_ch1    (s_second_ch1),
        .s_second_ch2    (s_second_ch2),
        .s_second_ch3    (s_second_ch3),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_sequence  (m_out_sequence),
        .m_out_ch0       (m_out_ch0),
        .m_out_ch1       (m_out_ch1),
        .m_out_ch2       (m_out_ch2),
        .m_out_ch3       (m_out_ch3),
        .m_out_last      (m_out_last),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .mismatches      (mismatches),
        .due_count       (due_count)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // runaway guard
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("sequence_reorder_buffer_core_tb: errors");
            $finish;
        end
    end

    // result side back-pressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= hold_pct);
    end

    // setup cycle, access cycle, register written at the access edge
    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // hold the sender until every predicted word is out and the block is quiet;
    // one edge first so the last accepted word is already in the prediction count
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (due_count != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    function automatic sample_set_t random_set();
        sample_set_t set;
        for (int c = 0; c < IN_CH; c++) begin
            case ($urandom_range(0, 9))
                0: set[c] = 16'h8000;
                1: set[c] = 16'h7FFF;
                default: set[c] = 16'($urandom);
            endcase
        end
        return set;
    endfunction

    task automatic send_packet(input logic [15:0] number, input sample_set_t first,
                               input sample_set_t second);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_packet_number <= number;
        s_first_ch0     <= first[0];
        s_first_ch1     <= first[1];
        s_first_ch2     <= first[2];
        s_first_ch3     <= first[3];
        s_second_ch0    <= second[0];
        s_second_ch1    <= second[1];
        s_second_ch2    <= second[2];
        s_second_ch3    <= second[3];
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // mostly a rising packet stream, with late words, jumps and noise mixed in
    task automatic run_phase(input logic [15:0] gain_word, input logic [15:0] window,
                             input int idle_pct, input int stall_pct,
                             input int jump_limit, input int stream_goal);
        int          streamed;
        int          pick;
        int          reach;
        logic [15:0] number;
        settle();
        apb_write(GAIN_ADDR, {16'h0000, gain_word});
        apb_write(MAX_DELAY_ADDR, {16'h0000, window});
        send_idle_pct = idle_pct;
        hold_pct      = stall_pct;
        reach         = (window > 16'd4000) ? 64 : int'(window) + 48;
        streamed      = 0;
        while (streamed < stream_goal) begin
            if ($urandom_range(0, 99) == 0)
                settle();
            pick = $urandom_range(0, 99);
            if (pick < 78) begin
                cursor += 16'($urandom_range(1, 3));
                number = cursor;
                streamed++;
            end else if (pick < 86) begin
                number = cursor - 16'($urandom_range(0, reach));
            end else if (pick < 92) begin
                cursor += 16'($urandom_range(0, jump_limit));
                number = cursor;
                streamed++;
            end else begin
                number = 16'($urandom);
            end
            send_packet(number, random_set(), random_set());
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: gain 1.5, late window of 16
        apb_write(GAIN_ADDR, 32'h0000_0180);
        apb_write(MAX_DELAY_ADDR, 32'd16);
        // empty store, extreme samples
        send_packet(16'd100, {16'hFFFF, 16'h0000, 16'h7FFF, 16'h8000},
                    {16'hFFFF, 16'h0001, 16'h8000, 16'h7FFF});
        // both keys already held
        send_packet(16'd100, random_set(), random_set());
        // one key held, one new
        send_packet(16'd101, random_set(), random_set());
        // late, then exactly at the late window
        send_packet(16'd90, random_set(), random_set());
        send_packet(16'd84, random_set(), random_set());
        // one past the window: new round
        send_packet(16'd83, random_set(), random_set());
        // extremes of the sequence number
        send_packet(16'd0, random_set(), random_set());
        send_packet(16'hFFFF, random_set(), random_set());
        // fill past the map size: one word, then two per packet
        for (int i = 0; i < 6; i++)
            send_packet(16'(200 + 2 * i), random_set(), random_set());

        cursor = 16'd300;
        run_phase(16'h8000, 16'hFFFF, 0, 63, 1000, 220);
        run_phase(16'h0100, 16'd1024, 0, 0, 65535, 220);
        run_phase(16'h7FFF, 16'd0, 63, 0, 65535, 220);
        run_phase(16'($urandom), 16'($urandom_range(0, 4095)), 35, 35, 65535, 220);
        run_phase(16'hFFFF, 16'd200, 35, 35, 65535, 220);

        settle();
        if (mismatches == 0) begin
            $display("sequence_reorder_buffer_core_tb: clean");
        end else begin
            $display("sequence_reorder_buffer_core_tb: errors");
        end
        $finish;
    end

endmodule
